>>> rtl/lpr_pkg.sv
// Shared types and constants for the linear parameter ramp.
`timescale 1ns / 1ps

package lpr_pkg;

  localparam int KIND_BITS = 2;
  // Extra fraction bits that the accumulator and step carry beyond Q16.16
  localparam int FRAC_EXT = 16;

  typedef logic [KIND_BITS-1:0] kind_t;

  localparam kind_t KIND_JUMP = 2'd0;
  localparam kind_t KIND_RAMP = 2'd1;
  localparam kind_t KIND_TICK = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIFF = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_FIX  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

endpackage

>>> rtl/linear_parameter_ramp.sv
// Top level of the linear parameter ramp: sequencer, state and result register.
//
//   channel  | signals                              | direction
//   item     | item_valid/item_ready, kind, value,  | in
//            | ramp_length                          |
//   result   | result_valid/result_ready,           | out
//            | current_value, ramping               |
//
// Jump, tick and unused kind: from idle straight to the emit state, which loads the result.
// A ramp with a nonzero length passes through the diff, divide and fix states before emit,
// the divide state waiting on the serial divider that produces one quotient bit per cycle.
// Synchronous reset clears the accumulator, goal, step and sample count to zero.
// item_ready is low while an item is in work; a result that is not taken
// holds the block at the point of loading the next result.
`timescale 1ns / 1ps

module linear_parameter_ramp #(
  parameter int VALUE_BITS = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  lpr_pkg::kind_t                kind,
  input  logic signed [VALUE_BITS-1:0]  value,
  input  logic [COUNT_BITS-1:0]         ramp_length,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic signed [VALUE_BITS-1:0]  current_value,
  output logic                          ramping
);

  import lpr_pkg::*;

  localparam int ACC_BITS = VALUE_BITS + FRAC_EXT;
  localparam logic [ACC_BITS-1:0] MAX_POS = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic [ACC_BITS-1:0] MAX_NEG = {1'b1, {(ACC_BITS-1){1'b0}}};

  state_t                  state;
  logic [ACC_BITS-1:0]     accumulator;
  logic [VALUE_BITS-1:0]   goal;
  logic [ACC_BITS-1:0]     step_size;
  logic [COUNT_BITS-1:0]   steps_left;
  logic                    step_neg;

  logic                    item_fire;
  logic                    emit_load;
  logic [ACC_BITS-1:0]     goal_wide;
  logic [ACC_BITS-1:0]     value_wide;
  logic [ACC_BITS:0]       diff;
  logic [ACC_BITS:0]       diff_abs;
  logic [ACC_BITS-1:0]     accum_sum;
  logic [COUNT_BITS-1:0]   steps_dec;
  logic                    div_done;
  logic [ACC_BITS-1:0]     quotient;
  logic [ACC_BITS-1:0]     step_mag;
  logic [ACC_BITS-1:0]     step_neg_val;

  assign item_ready = (state == ST_IDLE);
  assign item_fire  = item_valid && item_ready;
  assign emit_load  = (state == ST_EMIT) && (!result_valid || result_ready);

  assign goal_wide  = {goal, {FRAC_EXT{1'b0}}};
  assign value_wide = {value, {FRAC_EXT{1'b0}}};

  // Signed distance to the goal, one bit wider so it cannot overflow
  assign diff     = {goal_wide[ACC_BITS-1], goal_wide} -
                    {accumulator[ACC_BITS-1], accumulator};
  assign diff_abs = diff[ACC_BITS] ? (~diff + (ACC_BITS+1)'(1)) : diff;

  assign accum_sum = accumulator + step_size;
  assign steps_dec = steps_left - COUNT_BITS'(1);

  // Saturate the quotient to the step range, then apply the sign
  always_comb begin
    if (step_neg) begin
      step_mag = (quotient > MAX_NEG) ? MAX_NEG : quotient;
    end else begin
      step_mag = (quotient > MAX_POS) ? MAX_POS : quotient;
    end
    step_neg_val = ~step_mag + ACC_BITS'(1);
  end

  lpr_divider #(
    .DIVIDEND_BITS(ACC_BITS),
    .DIVISOR_BITS (COUNT_BITS)
  ) u_divider (
    .clk     (clk),
    .rst     (rst),
    .start   (state == ST_DIFF),
    .dividend(diff_abs[ACC_BITS-1:0]),
    .divisor (steps_left),
    .done    (div_done),
    .quotient(quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      accumulator  <= '0;
      goal         <= '0;
      step_size    <= '0;
      steps_left   <= '0;
      step_neg     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (emit_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (item_fire) begin
            case (kind)
              KIND_JUMP: begin
                state       <= ST_EMIT;
                goal        <= value;
                accumulator <= value_wide;
                step_size   <= '0;
                steps_left  <= '0;
              end
              KIND_RAMP: begin
                goal       <= value;
                steps_left <= ramp_length;
                if (ramp_length == '0) begin
                  state       <= ST_EMIT;
                  accumulator <= value_wide;
                  step_size   <= '0;
                end else begin
                  state <= ST_DIFF;
                end
              end
              KIND_TICK: begin
                state <= ST_EMIT;
                if (steps_left != '0) begin
                  steps_left <= steps_dec;
                  // Snap to the goal on the last sample
                  accumulator <= (steps_dec == '0) ? goal_wide : accum_sum;
                end
              end
              default: begin
                state <= ST_EMIT;
              end
            endcase
          end
        end
        ST_DIFF: begin
          step_neg <= diff[ACC_BITS];
          state    <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_FIX;
          end
        end
        ST_FIX: begin
          step_size <= step_neg ? step_neg_val : step_mag;
          state     <= ST_EMIT;
        end
        ST_EMIT: begin
          // Hold until the result slot is free
          if (emit_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      current_value <= accumulator[ACC_BITS-1:FRAC_EXT];
      ramping       <= (steps_left != '0);
    end
  end

endmodule

>>> rtl/lpr_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module lpr_divider #(
  parameter int DIVIDEND_BITS = 48,
  parameter int DIVISOR_BITS  = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [DIVIDEND_BITS-1:0] dividend,
  input  logic [DIVISOR_BITS-1:0]  divisor,
  output logic                     done,
  output logic [DIVIDEND_BITS-1:0] quotient
);

  localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

  logic                     busy;
  logic [CNT_BITS-1:0]      cnt;
  logic [DIVISOR_BITS-1:0]  rem;
  logic [DIVIDEND_BITS-1:0] quo;
  logic [DIVISOR_BITS:0]    rem_shift;
  logic                     fits;
  logic [DIVISOR_BITS:0]    rem_sub;
  logic [DIVISOR_BITS-1:0]  rem_next;

  // Quotient register also shifts the dividend out from the top
  assign rem_shift = {rem, quo[DIVIDEND_BITS-1]};
  assign fits      = rem_shift >= {1'b0, divisor};
  assign rem_sub   = rem_shift - {1'b0, divisor};
  assign rem_next  = fits ? rem_sub[DIVISOR_BITS-1:0] : rem_shift[DIVISOR_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // Pulse done once the last quotient bit is in
      done <= busy && !start && (cnt == CNT_BITS'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(DIVIDEND_BITS);
      end else if (busy) begin
        cnt <= cnt - CNT_BITS'(1);
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[DIVIDEND_BITS-2:0], fits};
      rem <= rem_next;
    end
  end

  assign quotient = quo;

endmodule

>>> bench/tb.sv
// Self-checking testbench for the linear parameter ramp: directed and random items.
`timescale 1ns / 1ps

module tb;
  import lpr_pkg::*;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 16;
  localparam int ACC_W = VALUE_W + FRAC_EXT;
  localparam int RANDOM_ITEMS = 1000;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 60;
  localparam kind_t KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [VALUE_W-1:0] current_value;
    logic                      ramping;
  } smoothed_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      item_valid;
  logic                      item_ready;
  kind_t                     kind;
  logic signed [VALUE_W-1:0] value;
  logic [COUNT_W-1:0]        ramp_length;
  logic                      result_valid;
  logic                      result_ready;
  logic signed [VALUE_W-1:0] current_value;
  logic                      ramping;

  // Predicted smoother state
  logic signed [ACC_W-1:0]   acc_q = '0;
  logic signed [VALUE_W-1:0] goal_q = '0;
  logic signed [ACC_W-1:0]   step_q = '0;
  logic [COUNT_W-1:0]        left_q = '0;

  smoothed_t smoothed_q[$];
  int        errors = 0;
  int        cycles = 0;
  int        active_items = 0;
  int        burst_left = 0;

  linear_parameter_ramp #(
    .VALUE_BITS(VALUE_W),
    .COUNT_BITS(COUNT_W)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .kind(kind),
    .value(value),
    .ramp_length(ramp_length),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .current_value(current_value),
    .ramping(ramping)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Per-sample increment: (goal - accumulator) / count, rounded toward zero, saturated
  function automatic logic signed [ACC_W-1:0] ramp_increment(
    input logic signed [ACC_W-1:0] from,
    input logic signed [VALUE_W-1:0] to,
    input logic [COUNT_W-1:0] count
  );
    logic signed [ACC_W+1:0] target_w;
    logic signed [ACC_W+1:0] from_w;
    logic signed [ACC_W+1:0] span;
    logic [ACC_W:0]          mag;
    logic [ACC_W:0]          quo;
    logic [ACC_W:0]          sat;
    logic                    neg;
    target_w = $signed({to, {FRAC_EXT{1'b0}}});
    from_w = from;
    span = target_w - from_w;
    neg = span < 0;
    mag = neg ? -span : span;
    quo = mag / {{(ACC_W + 1 - COUNT_W){1'b0}}, count};
    if (!neg) begin
      sat = (quo > {2'b00, {(ACC_W-1){1'b1}}}) ? {2'b00, {(ACC_W-1){1'b1}}} : quo;
    end else begin
      sat = (quo > {2'b01, {(ACC_W-1){1'b0}}}) ? {2'b01, {(ACC_W-1){1'b0}}} : quo;
    end
    return neg ? (~sat[ACC_W-1:0] + 1'b1) : sat[ACC_W-1:0];
  endfunction

  task automatic advance_smoother(input kind_t k, input logic signed [VALUE_W-1:0] v,
                                  input logic [COUNT_W-1:0] n);
    smoothed_t res;
    case (k)
      KIND_JUMP: begin
        goal_q = v;
        acc_q = {v, {FRAC_EXT{1'b0}}};
        step_q = '0;
        left_q = '0;
      end
      KIND_RAMP: begin
        goal_q = v;
        left_q = n;
        if (n == 0) begin
          acc_q = {v, {FRAC_EXT{1'b0}}};
          step_q = '0;
        end else begin
          step_q = ramp_increment(acc_q, v, n);
        end
      end
      KIND_TICK: begin
        if (left_q != 0) begin
          acc_q = acc_q + step_q;
          left_q = left_q - 1'b1;
          // snap exactly onto the goal at the last sample
          if (left_q == 0) acc_q = {goal_q, {FRAC_EXT{1'b0}}};
        end
      end
      default: ;
    endcase
    res.current_value = acc_q[ACC_W-1:FRAC_EXT];
    res.ramping = (left_q != 0);
    smoothed_q = {smoothed_q, res};
  endtask

  // Sender bursts: run back-to-back for a while, then drop valid for a gap
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 15);
      @(negedge clk);
      item_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_item(input kind_t k, input logic signed [VALUE_W-1:0] v,
                           input logic [COUNT_W-1:0] n);
    pace();
    @(negedge clk);
    item_valid <= 1'b1;
    kind <= k;
    value <= v;
    ramp_length <= n;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    if (k == KIND_JUMP || k == KIND_RAMP || (k == KIND_TICK && left_q != 0)) active_items++;
    advance_smoother(k, v, n);
  endtask

  task automatic wait_results_drained();
    while (smoothed_q.size() != 0) @(posedge clk);
  endtask

  // Check each result transaction against the oldest prediction
  always @(posedge clk) begin
    smoothed_t exp_res;
    if (!rst && result_valid && result_ready) begin
      if (smoothed_q.size() == 0) begin
        $error("unexpected result: current_value %0d, ramping %0d", current_value, ramping);
        errors++;
      end else begin
        exp_res = smoothed_q.pop_front();
        if (current_value !== exp_res.current_value) begin
          $error("current_value: expected %0d, got %0d", exp_res.current_value, current_value);
          errors++;
        end
        if (ramping !== exp_res.ramping) begin
          $error("ramping: expected %0d, got %0d", exp_res.ramping, ramping);
          errors++;
        end
      end
    end
  end

  // Receiver stalls in modes: always ready, coin flip, mostly ready, long stalls
  initial begin
    int mode;
    int span;
    result_ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: result_ready <= 1'b1;
          1: result_ready <= ($urandom_range(0, 1) == 1);
          2: result_ready <= ($urandom_range(0, 7) != 0);
          default: result_ready <= ($urandom_range(0, 15) == 0);
        endcase
      end
    end
  end

  task automatic test_jumps();
    send_item(KIND_JUMP, 32'sh7FFF_FFFF, 16'hFFFF);
    send_item(KIND_JUMP, 32'sh8000_0000, 16'h0000);
    send_item(KIND_JUMP, 32'sh0000_0000, 16'h5A5A);
  endtask

  task automatic test_idle_and_unused();
    send_item(KIND_TICK, $urandom, COUNT_W'($urandom_range(0, 65535)));
    send_item(KIND_UNUSED, $urandom, COUNT_W'($urandom_range(0, 65535)));
  endtask

  task automatic test_ramp_extremes();
    send_item(KIND_JUMP, 32'sh8000_0000, 16'd0);
    // full-scale span in one sample saturates the increment
    send_item(KIND_RAMP, 32'sh7FFF_FFFF, 16'd1);
    send_item(KIND_TICK, 32'sh0, 16'd0);
    send_item(KIND_RAMP, -32'sd1, 16'd0);
    send_item(KIND_RAMP, 32'sh7FFF_FFFF, 16'hFFFF);
    repeat (2) send_item(KIND_TICK, 32'sh0, 16'd0);
    send_item(KIND_RAMP, 32'sh8000_0000, 16'd3);
    repeat (4) send_item(KIND_TICK, 32'sh0, 16'd0);
  endtask

  task automatic test_retarget();
    send_item(KIND_RAMP, 32'sd100 <<< 16, 16'd4);
    send_item(KIND_TICK, 32'sh0, 16'd0);
    send_item(KIND_UNUSED, 32'sh1234_5678, 16'd9);
    send_item(KIND_RAMP, -(32'sd50 <<< 16), 16'd2);
    repeat (2) send_item(KIND_TICK, 32'sh0, 16'd0);
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    if ($urandom_range(0, 1) == 0) return $urandom;
    return $urandom_range(0, 32'h003F_FFFF) - 32'h0020_0000;
  endfunction

  function automatic logic [COUNT_W-1:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return COUNT_W'($urandom_range(1, 8));
    if (r < 85) return COUNT_W'($urandom_range(9, 40));
    if (r < 95) return '0;
    return COUNT_W'($urandom_range(0, 65535));
  endfunction

  task automatic test_random();
    int seq = 0;
    int ticks;
    logic [COUNT_W-1:0] n;
    while (active_items < RANDOM_ITEMS + 23) begin
      seq++;
      // hold off now and then until every result is back
      if (seq % 97 == 1) begin
        @(negedge clk);
        item_valid <= 1'b0;
        burst_left = 0;
        wait_results_drained();
      end
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 1) == 0) send_item(KIND_JUMP, pick_value(), COUNT_W'($urandom));
        n = pick_length();
        send_item(KIND_RAMP, pick_value(), n);
        ticks = (n > 40) ? $urandom_range(1, 40) : n + $urandom_range(0, 2);
        // sometimes cut the ramp short with a new target
        if (ticks > 1 && $urandom_range(0, 4) == 0) ticks = $urandom_range(1, ticks - 1);
        repeat (ticks) send_item(KIND_TICK, $urandom, COUNT_W'($urandom));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_item(kind_t'($urandom_range(0, 3)), pick_value(),
                    ($urandom_range(0, 4) == 0) ? COUNT_W'($urandom_range(0, 65535))
                                                : pick_length());
        end
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    kind = KIND_JUMP;
    value = '0;
    ramp_length = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_jumps();
    test_idle_and_unused();
    test_ramp_extremes();
    test_retarget();
    test_random();

    @(negedge clk);
    item_valid <= 1'b0;
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && smoothed_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

>>> linear_parameter_ramp.f
rtl/lpr_pkg.sv
rtl/lpr_divider.sv
rtl/linear_parameter_ramp.sv
bench/tb.sv
